[rtl/core/vnis_pkg.sv]
// shared types and constants for the vector normalize / square root block
package vnis_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int OP_W          = 2;
  localparam int COMP_W        = 15;
  localparam int RAD_W         = 32;
  localparam int NORM_W        = 14;
  localparam int SCALAR_W      = 30;
  localparam int DIV_W         = 32;  // divider operand width
  localparam int CNT_W         = 6;   // divider bit counter

  typedef enum logic [OP_W-1:0] {
    OP_NORM  = 2'd0,
    OP_ISQRT = 2'd1,
    OP_SQRT  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_NEWTON_DIV,
    ST_NEWTON_WAIT,
    ST_NEWTON_UPD,
    ST_COMP_DIV,
    ST_COMP_WAIT,
    ST_COMP_STORE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input item
    logic sq_step;     // accumulate one squared component
    logic newton_init; // seed r with the operand
    logic newton_div;  // start a / r
    logic newton_upd;  // form next r
    logic comp_div;    // start component divide
    logic comp_store;  // store component quotient
    logic [1:0] comp_sel;
    logic out_load;    // move result to output register
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic newton_stop; // next r not smaller than r
    logic root_zero;   // operand not positive or root zero
    logic sq_last;
    logic is_norm;
  } stat_t;

endpackage

[rtl/core/vnis_div.sv]
// restoring divider, one quotient bit per cycle
module vnis_div
  import vnis_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DIV_W-1]} - {1'b0, dsr_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[DIV_W]) begin
        rem_nxt = {rem_r[DIV_W-2:0], quo_r[DIV_W-1]};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/core/vnis_dp.sv]
// datapath: squared length, newton root and component scaling
module vnis_dp
  import vnis_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_t                    ctrl,
  output stat_t                    stat,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [COMP_W-1:0] in_x,
  input  logic signed [COMP_W-1:0] in_y,
  input  logic signed [COMP_W-1:0] in_z,
  input  logic signed [RAD_W-1:0]  in_rad,
  output logic [NORM_W-1:0]        res_x,
  output logic [NORM_W-1:0]        res_y,
  output logic [NORM_W-1:0]        res_z,
  output logic [SCALAR_W-1:0]      res_scalar
);

  localparam int SQ_W = 2 * COMP_W + 1;

  opcode_t                    op_r;
  logic signed [COMP_W-1:0]   comp_r [3];
  logic [1:0]                 sq_idx_r;
  logic [SQ_W-1:0]            sq_r;
  logic [DIV_W-1:0]           opnd_r;   // newton operand a
  logic [DIV_W-1:0]           root_r;
  logic [DIV_W:0]             nxt_root;
  logic [NORM_W-1:0]          norm_r [3];
  logic [NORM_W-1:0]          ox_r, oy_r, oz_r;
  logic [SCALAR_W-1:0]        osc_r;
  logic                       div_start;
  logic [DIV_W-1:0]           div_a, div_b, div_q;
  logic                       div_done;
  logic signed [COMP_W-1:0]   cur_comp;
  logic [COMP_W-1:0]          comp_mag;
  logic signed [RAD_W-1:0]    rad_q;
  logic signed [RAD_W-1:0]    rad_r;
  logic signed [2*COMP_W-1:0] prod;
  logic [DIV_W-1:0]           quo_neg;
  logic [SCALAR_W-1:0]        scal_nxt;

  vnis_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cur_comp = comp_r[ctrl.comp_sel];
  assign comp_mag = cur_comp[COMP_W-1] ? COMP_W'(-cur_comp) : COMP_W'(cur_comp);
  assign div_start = ctrl.newton_div | ctrl.comp_div;
  assign div_a = ctrl.comp_div ? (DIV_W'(comp_mag) << FRAC_BITS) : opnd_r;
  assign div_b = root_r;
  assign nxt_root = ({1'b0, root_r} + {1'b0, div_q}) >> 1;
  assign prod = cur_comp * cur_comp;
  // truncating divide by a power of two: bias negatives before shifting
  assign rad_q = (rad_r + (rad_r[RAD_W-1] ? RAD_W'((1 << FRAC_BITS) - 1) : RAD_W'(0)))
                 >>> FRAC_BITS;
  assign quo_neg = cur_comp[COMP_W-1] ? DIV_W'(-div_q) : div_q;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r     <= opcode_t'(in_opcode);
      comp_r[0] <= in_x;
      comp_r[1] <= in_y;
      comp_r[2] <= in_z;
      rad_r    <= in_rad;
      sq_r     <= '0;
      norm_r[0] <= '0;
      norm_r[1] <= '0;
      norm_r[2] <= '0;
    end
    if (ctrl.sq_step) sq_r <= sq_r + SQ_W'(unsigned'(prod));
    if (ctrl.newton_init) begin
      if (op_r == OP_NORM) opnd_r <= DIV_W'(sq_r);
      else if (op_r == OP_SQRT) opnd_r <= rad_q[RAD_W-1] ? '0 : DIV_W'(rad_q);
      else if (op_r == OP_ISQRT) opnd_r <= rad_r[RAD_W-1] ? '0 : DIV_W'(rad_r);
      else opnd_r <= '0;
      if (op_r == OP_NORM) root_r <= DIV_W'(sq_r);
      else if (op_r == OP_SQRT) root_r <= rad_q[RAD_W-1] ? '0 : DIV_W'(rad_q);
      else if (op_r == OP_ISQRT) root_r <= rad_r[RAD_W-1] ? '0 : DIV_W'(rad_r);
      else root_r <= '0;
    end
    if (ctrl.newton_upd) root_r <= nxt_root[DIV_W-1:0];
    if (ctrl.comp_store) norm_r[ctrl.comp_sel] <= quo_neg[NORM_W-1:0];
    if (ctrl.out_load) begin
      ox_r  <= norm_r[0];
      oy_r  <= norm_r[1];
      oz_r  <= norm_r[2];
      osc_r <= scal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_idx_r <= '0;
    else if (ctrl.load) sq_idx_r <= '0;
    else if (ctrl.sq_step) sq_idx_r <= sq_idx_r + 1'b1;
  end

  always_comb begin
    unique case (op_r)
      OP_NORM:  scal_nxt = SCALAR_W'(sq_r);
      OP_ISQRT: scal_nxt = SCALAR_W'(root_r);
      OP_SQRT:  scal_nxt = SCALAR_W'(root_r << FRAC_BITS);
      default:  scal_nxt = '0;
    endcase
  end

  assign stat.div_done    = div_done;
  assign stat.newton_stop = nxt_root >= {1'b0, root_r};
  assign stat.root_zero   = root_r == '0;
  assign stat.sq_last     = sq_idx_r == 2'd2;
  assign stat.is_norm     = op_r == OP_NORM;

  assign res_x      = ox_r;
  assign res_y      = oy_r;
  assign res_z      = oz_r;
  assign res_scalar = osc_r;

endmodule

[rtl/core/vnis_ctrl.sv]
// controller state machine sequencing the shared divider
module vnis_ctrl
  import vnis_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  logic  out_free,  // output register empty or being drained
  output logic  busy,
  output logic  out_set,
  output ctrl_t ctrl,
  input  stat_t stat
);

  state_t     state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    ctrl      = '0;
    ctrl.comp_sel = sel_r;
    out_set   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ctrl.load = 1'b1;
          sel_nxt   = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (stat.is_norm) begin
          ctrl.sq_step = 1'b1;
          sel_nxt = sel_r + 1'b1;
          if (stat.sq_last) state_nxt = ST_NEWTON_DIV;
        end else begin
          state_nxt = ST_NEWTON_DIV;
        end
        if (stat.sq_last || !stat.is_norm) ctrl.newton_init = 1'b0;
      end
      ST_NEWTON_DIV: begin
        // entered once: seeds r; updates loop back to the wait state
        ctrl.newton_init = 1'b1;
        state_nxt = ST_NEWTON_WAIT;
      end
      ST_NEWTON_WAIT: begin
        if (stat.root_zero) begin
          sel_nxt = '0;
          state_nxt = ST_DONE;
        end else begin
          ctrl.newton_div = 1'b1;
          state_nxt = ST_NEWTON_UPD;
        end
      end
      ST_NEWTON_UPD: begin
        if (stat.div_done) begin
          if (stat.newton_stop) begin
            sel_nxt   = '0;
            state_nxt = stat.is_norm ? ST_COMP_DIV : ST_DONE;
          end else begin
            ctrl.newton_upd = 1'b1;
            state_nxt = ST_NEWTON_WAIT;
          end
        end
      end
      ST_COMP_DIV: begin
        ctrl.comp_div = 1'b1;
        state_nxt = ST_COMP_WAIT;
      end
      ST_COMP_WAIT: begin
        if (stat.div_done) state_nxt = ST_COMP_STORE;
      end
      ST_COMP_STORE: begin
        ctrl.comp_store = 1'b1;
        sel_nxt = sel_r + 1'b1;
        state_nxt = (sel_r == 2'd2) ? ST_DONE : ST_COMP_DIV;
      end
      ST_DONE: begin
        if (out_free) begin
          ctrl.out_load = 1'b1;
          out_set   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = state_r != ST_IDLE;

endmodule

[rtl/core/vector_normalize_isqrt.sv]
// top level: vector normalize and newton square root block
// One item is worked at a time. Opcode 0 first sums the squared
// components for the length, then runs the newton square root on the shared
// restoring divider, one divide an iteration, then three component divides.
// Opcodes 1 and 2 run only the root. The result sits in an output register
// so the next item is accepted while it waits to be taken.
module vector_normalize_isqrt
  import vnis_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[1:0], vec_x[16:2], vec_y[31:17], vec_z[46:32], radicand[78:47], zero fill
  input  logic [79:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // norm_x[13:0], norm_y[27:14], norm_z[41:28], scalar_value[71:42]
  output logic [71:0]  out_tdata
);

  ctrl_t               ctrl;
  stat_t               stat;
  logic                busy;
  logic                out_set;
  logic                in_fire;
  logic                out_valid_r;
  logic                out_free;
  logic [NORM_W-1:0]   rx, ry, rz;
  logic [SCALAR_W-1:0] rs;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  // output register frees when drained this cycle
  assign out_free  = !out_valid_r || out_tready;

  vnis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .busy     (busy),
    .out_set  (out_set),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  vnis_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_opcode  (in_tdata[1:0]),
    .in_x       (in_tdata[16:2]),
    .in_y       (in_tdata[31:17]),
    .in_z       (in_tdata[46:32]),
    .in_rad     (in_tdata[78:47]),
    .res_x      (rx),
    .res_y      (ry),
    .res_z      (rz),
    .res_scalar (rs)
  );

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_set) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {rs, rz, ry, rx};

  // a new result only lands when the register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_set |-> (!out_valid_r || out_tready))
    else $error("result overwritten before transfer");

  // an accepted input transfer puts the item in work
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy)
    else $error("accepted item not in work");

  // a result is produced only by a busy controller
  a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_set |-> busy)
    else $error("result without item");

endmodule
